FILE: rtl/core/lis_pkg.sv
// Shared types and constants of the line indent shifter.
package lis_pkg;

  localparam int TAB_CNT_W  = 12;
  localparam int SPACE_W    = 5;
  localparam int TABW_W     = 6;
  localparam int SHIFT_W    = 8;
  localparam int BYTE_W     = 8;
  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 8;

  localparam logic [CFG_IDX_W-1:0] REG_TAB_WIDTH  = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SHIFT_AMT  = 8'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SHIFT_LEFT = 8'd2;
  localparam logic [CFG_IDX_W-1:0] REG_KEEP_EMPTY = 8'd3;

  localparam logic [BYTE_W-1:0] CH_TAB   = 8'h09;
  localparam logic [BYTE_W-1:0] CH_SPACE = 8'h20;

  localparam logic [TABW_W-1:0]  TAB_MIN       = 6'd1;
  localparam logic [TABW_W-1:0]  TAB_MAX       = 6'd32;
  localparam logic [TABW_W-1:0]  TAB_RESET     = 6'd8;
  localparam logic [SHIFT_W-1:0] SHIFT_RESET   = 8'd8;

  typedef struct packed {
    logic [BYTE_W-1:0] text_byte;
    logic              byte_present;
    logic              line_end;
  } lis_in_t;

  typedef struct packed {
    logic [BYTE_W-1:0]    out_byte;
    logic                 out_byte_present;
    logic                 indent_valid;
    logic [TAB_CNT_W-1:0] tab_count;
    logic [SPACE_W-1:0]   space_count;
    logic                 line_changed;
    logic                 out_line_end;
  } lis_out_t;

  typedef struct packed {
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] wdata;
  } lis_cfg_t;

  // Classified item handed from front to back.
  typedef struct packed {
    logic [BYTE_W-1:0] out_byte;
    logic              byte_present;
    logic              indent_valid;
    logic              changed;
    logic              line_end;
  } lis_cmd_t;

endpackage

FILE: rtl/core/lis_stream_if.sv
// Valid/ready channel carrying one payload beat.
interface lis_stream_if #(
  parameter type T = logic
) ();
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

FILE: rtl/core/lis_queue.sv
// Short FIFO between the front and back parts.
module lis_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             push_ready,
  input  logic             pop,
  output logic             pop_valid,
  output logic [WIDTH-1:0] pop_data
);
  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign push_ready = (count != CNT_W'(DEPTH));
  assign pop_valid  = (count != '0);
  assign pop_data   = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end
endmodule

FILE: rtl/core/lis_front.sv
// Front part: tracks the leading whitespace and classifies each byte.
module lis_front #(
  parameter int COL_W      = 12,
  parameter int MAX_COLUMN = 4095
) (
  input  logic                        clk,
  input  logic                        rst,
  lis_stream_if.sink                  feed,
  input  logic [lis_pkg::TABW_W-1:0]  tab_eff,
  input  logic [lis_pkg::SHIFT_W-1:0] shift_amount,
  input  logic                        shift_left,
  input  logic                        keep_empty_lines,
  input  logic                        q_ready,
  output logic                        push,
  output lis_pkg::lis_cmd_t           cmd,
  output logic [COL_W-1:0]            new_col
);
  localparam logic [COL_W:0] MAX_EXT = (COL_W + 1)'(MAX_COLUMN);

  logic                               in_indent;
  logic [COL_W-1:0]                   column;
  logic [lis_pkg::SPACE_W-1:0]        tab_phase;

  lis_pkg::lis_in_t                   d;
  logic                               accept;
  logic                               produce;
  logic                               is_space;
  logic                               is_ws;
  logic [lis_pkg::SPACE_W-1:0]        ph;
  logic [lis_pkg::TABW_W-1:0]         ph_inc;
  logic [lis_pkg::TABW_W-1:0]         step;
  logic [lis_pkg::SPACE_W-1:0]        phase_adv;
  logic [COL_W:0]                     col_sum;
  logic [COL_W-1:0]                   col_adv;
  logic [COL_W-1:0]                   old_col;
  logic [COL_W-1:0]                   shift_ext;
  logic [COL_W:0]                     right_sum;
  logic                               empty_line;

  assign d           = feed.data;
  assign feed.ready  = q_ready;
  assign accept      = feed.valid && q_ready;
  assign produce     = d.byte_present || d.line_end;
  assign is_space    = d.byte_present && (d.text_byte == lis_pkg::CH_SPACE);
  assign is_ws       = is_space || (d.byte_present && (d.text_byte == lis_pkg::CH_TAB));

  always_comb begin
    ph        = ({1'b0, tab_phase} >= tab_eff) ? '0 : tab_phase;
    ph_inc    = {1'b0, ph} + 1'b1;
    if (is_space) begin
      step      = lis_pkg::TABW_W'(1);
      phase_adv = (ph_inc == tab_eff) ? '0 : ph_inc[lis_pkg::SPACE_W-1:0];
    end else begin
      step      = tab_eff - {1'b0, ph};
      phase_adv = '0;
    end
    col_sum   = {1'b0, column} + (COL_W + 1)'(step);
    col_adv   = (col_sum > MAX_EXT) ? MAX_EXT[COL_W-1:0] : col_sum[COL_W-1:0];
    old_col   = is_ws ? col_adv : column;
    shift_ext = COL_W'(shift_amount);
    right_sum = {1'b0, old_col} + {1'b0, shift_ext};
    empty_line = !d.byte_present && (column == '0);

    if (empty_line && !keep_empty_lines) begin
      new_col = '0;
    end else if (shift_left) begin
      new_col = (old_col > shift_ext) ? old_col - shift_ext : '0;
    end else begin
      new_col = (right_sum > MAX_EXT) ? MAX_EXT[COL_W-1:0] : right_sum[COL_W-1:0];
    end

    cmd.byte_present = d.byte_present && !(in_indent && is_ws);
    cmd.out_byte     = cmd.byte_present ? d.text_byte : '0;
    cmd.indent_valid = in_indent && (!is_ws || d.line_end);
    cmd.changed      = !(empty_line && !keep_empty_lines) && (new_col != old_col);
    cmd.line_end     = d.line_end;
  end

  // leading whitespace only moves the column
  assign push = accept && produce && !(in_indent && is_ws && !d.line_end);

  always_ff @(posedge clk) begin
    if (rst) begin
      in_indent <= 1'b1;
      column    <= '0;
      tab_phase <= '0;
    end else if (accept && produce) begin
      if (d.line_end) begin
        in_indent <= 1'b1;
        column    <= '0;
        tab_phase <= '0;
      end else if (in_indent) begin
        if (is_ws) begin
          column    <= col_adv;
          tab_phase <= phase_adv;
        end else begin
          in_indent <= 1'b0;
        end
      end
    end
  end
endmodule

FILE: rtl/core/lis_back.sv
// Back part: splits the new column into tabs and spaces, drives results.
module lis_back #(
  parameter int COL_W = 12
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic [lis_pkg::TABW_W-1:0] tab_eff,
  input  logic                       q_valid,
  input  lis_pkg::lis_cmd_t          q_cmd,
  input  logic [COL_W-1:0]           q_col,
  output logic                       q_pop,
  lis_stream_if.source               result
);
  localparam int CNT_W = $clog2(COL_W);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_DIV  = 2'd1;
  localparam logic [1:0] S_DONE = 2'd2;

  logic [1:0]                   state;
  logic [1:0]                   state_next;
  lis_pkg::lis_cmd_t            hold;
  logic [COL_W-1:0]             dvd;
  logic [lis_pkg::SPACE_W-1:0]  rem;
  logic [CNT_W-1:0]             cnt;
  logic                         out_valid;
  lis_pkg::lis_out_t            out_data;

  logic                         out_free;
  logic                         take_div;
  logic                         take_pass;
  logic                         done_load;
  logic [lis_pkg::TABW_W-1:0]   trial;
  logic                         ge;
  logic [lis_pkg::SPACE_W-1:0]  rem_next;

  assign result.valid = out_valid;
  assign result.data  = out_data;

  assign out_free  = !out_valid || result.ready;
  assign take_div  = (state == S_IDLE) && q_valid && q_cmd.indent_valid;
  assign take_pass = (state == S_IDLE) && q_valid && !q_cmd.indent_valid && out_free;
  assign done_load = (state == S_DONE) && out_free;
  assign q_pop     = take_div || take_pass;

  assign trial    = {rem, dvd[COL_W-1]};
  assign ge       = (trial >= tab_eff);
  assign rem_next = ge ? lis_pkg::SPACE_W'(trial - tab_eff) : trial[lis_pkg::SPACE_W-1:0];

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (take_div) begin
          state_next = S_DIV;
        end
      end
      S_DIV: begin
        if (cnt == CNT_W'(COL_W - 1)) begin
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        if (done_load) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      cnt       <= '0;
    end else begin
      state <= state_next;
      if (take_pass || done_load) begin
        out_valid <= 1'b1;
      end else if (result.ready) begin
        out_valid <= 1'b0;
      end
      if (take_div) begin
        cnt <= '0;
      end else if (state == S_DIV) begin
        cnt <= cnt + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take_div) begin
      hold <= q_cmd;
      dvd  <= q_col;
      rem  <= '0;
    end else if (state == S_DIV) begin
      dvd <= {dvd[COL_W-2:0], ge};
      rem <= rem_next;
    end
    if (take_pass) begin
      out_data.out_byte         <= q_cmd.out_byte;
      out_data.out_byte_present <= q_cmd.byte_present;
      out_data.indent_valid     <= 1'b0;
      out_data.tab_count        <= '0;
      out_data.space_count      <= '0;
      out_data.line_changed     <= 1'b0;
      out_data.out_line_end     <= q_cmd.line_end;
    end else if (done_load) begin
      out_data.out_byte         <= hold.out_byte;
      out_data.out_byte_present <= hold.byte_present;
      out_data.indent_valid     <= 1'b1;
      out_data.tab_count        <= lis_pkg::TAB_CNT_W'(dvd);
      out_data.space_count      <= rem;
      out_data.line_changed     <= hold.changed;
      out_data.out_line_end     <= hold.line_end;
    end
  end
endmodule

FILE: rtl/core/line_indent_shifter.sv
// Line indent shifter top level: config registers, front, queue, back.
// Path: a plain byte goes from its taken beat through the queue and the
// back's output register; an indent close also passes S_DIV, run by the
// back's one-bit-per-cycle tab divider, and S_DONE, keeping the back busy.
// Throughput: one beat per cycle while the queue has room.
// Reset (rst, synchronous) sets registers to their defaults and the line start.
module line_indent_shifter #(
  parameter int MAX_COLUMN = 4095
) (
  input  logic        clk,
  input  logic        rst,
  lis_stream_if.sink   cfg,
  lis_stream_if.sink   feed,
  lis_stream_if.source result
);
  localparam int COL_W = $clog2(MAX_COLUMN + 1);
  localparam int CMD_W = $bits(lis_pkg::lis_cmd_t);

  logic [lis_pkg::TABW_W-1:0]  tab_width;
  logic [lis_pkg::SHIFT_W-1:0] shift_amount;
  logic                        shift_left;
  logic                        keep_empty_lines;
  logic [lis_pkg::TABW_W-1:0]  tab_eff;
  lis_pkg::lis_cfg_t           cw;

  logic                        q_push;
  logic                        q_ready;
  logic                        q_pop;
  logic                        q_valid;
  lis_pkg::lis_cmd_t           push_cmd;
  logic [COL_W-1:0]            push_col;
  logic [CMD_W+COL_W-1:0]      pop_data;
  lis_pkg::lis_cmd_t           pop_cmd;
  logic [COL_W-1:0]            pop_col;

  assign cw        = cfg.data;
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      tab_width        <= lis_pkg::TAB_RESET;
      shift_amount     <= lis_pkg::SHIFT_RESET;
      shift_left       <= 1'b0;
      keep_empty_lines <= 1'b0;
    end else if (cfg.valid) begin
      case (cw.index)
        lis_pkg::REG_TAB_WIDTH:  tab_width        <= cw.wdata[lis_pkg::TABW_W-1:0];
        lis_pkg::REG_SHIFT_AMT:  shift_amount     <= cw.wdata;
        lis_pkg::REG_SHIFT_LEFT: shift_left       <= cw.wdata[0];
        lis_pkg::REG_KEEP_EMPTY: keep_empty_lines <= cw.wdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (tab_width == '0) begin
      tab_eff = lis_pkg::TAB_MIN;
    end else if (tab_width > lis_pkg::TAB_MAX) begin
      tab_eff = lis_pkg::TAB_MAX;
    end else begin
      tab_eff = tab_width;
    end
  end

  lis_front #(
    .COL_W      (COL_W),
    .MAX_COLUMN (MAX_COLUMN)
  ) u_front (
    .clk              (clk),
    .rst              (rst),
    .feed             (feed),
    .tab_eff          (tab_eff),
    .shift_amount     (shift_amount),
    .shift_left       (shift_left),
    .keep_empty_lines (keep_empty_lines),
    .q_ready          (q_ready),
    .push             (q_push),
    .cmd              (push_cmd),
    .new_col          (push_col)
  );

  lis_queue #(
    .WIDTH (CMD_W + COL_W),
    .DEPTH (2)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (q_push),
    .push_data  ({push_cmd, push_col}),
    .push_ready (q_ready),
    .pop        (q_pop),
    .pop_valid  (q_valid),
    .pop_data   (pop_data)
  );

  assign pop_cmd = pop_data[CMD_W+COL_W-1:COL_W];
  assign pop_col = pop_data[COL_W-1:0];

  lis_back #(
    .COL_W (COL_W)
  ) u_back (
    .clk     (clk),
    .rst     (rst),
    .tab_eff (tab_eff),
    .q_valid (q_valid),
    .q_cmd   (pop_cmd),
    .q_col   (pop_col),
    .q_pop   (q_pop),
    .result  (result)
  );

  a_no_indent_fields: assert property (@(posedge clk) disable iff (rst)
    result.valid && !result.data.indent_valid |->
      result.data.tab_count == '0 && result.data.space_count == '0 &&
      !result.data.line_changed)
    else $error("indent fields set on a plain beat");

  a_space_below_tab: assert property (@(posedge clk) disable iff (rst)
    result.valid && result.data.indent_valid |->
      {1'b0, result.data.space_count} < tab_eff)
    else $error("space count not below tab width");

  a_byte_zero: assert property (@(posedge clk) disable iff (rst)
    result.valid && !result.data.out_byte_present |-> result.data.out_byte == '0)
    else $error("out byte set without a byte");

  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> q_valid)
    else $error("queue popped while empty");
endmodule

FILE: tb/sv/tb.sv
// Testbench for line_indent_shifter: queued text and register beats, predicted reindent results.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_COL      = 4095;
  localparam int SETTLE_CYC   = 40;
  localparam int LIMIT_CYCLES = 400000;
  localparam int TEXT_TARGET  = 850;

  typedef enum logic [1:0] {OP_TEXT, OP_REG, OP_SETTLE} feed_kind_t;

  typedef struct {
    feed_kind_t        kind;
    lis_pkg::lis_in_t  text;
    lis_pkg::lis_cfg_t reg_wr;
  } feed_op_t;

  logic clk;
  logic rst;

  lis_stream_if #(.T(lis_pkg::lis_cfg_t)) cfg_ch ();
  lis_stream_if #(.T(lis_pkg::lis_in_t))  feed_ch ();
  lis_stream_if #(.T(lis_pkg::lis_out_t)) res_ch ();

  line_indent_shifter #(.MAX_COLUMN(MAX_COL)) dut (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg_ch),
    .feed   (feed_ch),
    .result (res_ch)
  );

  feed_op_t          feed_ops[$];
  lis_pkg::lis_out_t awaited[$];
  int unsigned       text_items;
  int unsigned       mismatches;
  int unsigned       cycles_run;

  // predictor state and register shadow
  bit          in_indent    = 1'b1;
  int unsigned column       = 0;
  int unsigned tab_phase    = 0;
  logic [5:0]  tab_width_r  = lis_pkg::TAB_RESET;
  logic [7:0]  shift_r      = lis_pkg::SHIFT_RESET;
  bit          shift_left_r = 1'b0;
  bit          keep_empty_r = 1'b0;

  // driver and monitor state
  bit          feed_v_next;
  bit          cfg_v_next;
  int          feed_gap;
  int          settle_cnt;
  int          feed_idle_mode;
  int          res_hold;
  int          res_idle_mode;

  initial clk = 1'b0;
  always #2 clk = ~clk;

  function automatic int draw_wait(int mode);
    case (mode)
      0: return 0;
      1: return $urandom_range(0, 18);
      default: return ($urandom_range(0, 7) == 0) ? $urandom_range(1, 18) : 0;
    endcase
  endfunction

  task automatic add_text(logic [7:0] b, bit present, bit last);
    feed_op_t op;
    op.kind   = OP_TEXT;
    op.reg_wr = '0;
    if ($urandom_range(0, 19) == 0) begin
      op.text = '{text_byte: 8'($urandom_range(0, 255)), byte_present: 1'b0, line_end: 1'b0};
      feed_ops.push_back(op);
    end
    op.text = '{text_byte: b, byte_present: present, line_end: last};
    feed_ops.push_back(op);
    if (present || last) text_items++;
  endtask

  task automatic add_reg(logic [lis_pkg::CFG_IDX_W-1:0] idx,
                         logic [lis_pkg::CFG_DATA_W-1:0] val);
    feed_op_t op;
    op.kind   = OP_REG;
    op.text   = '0;
    op.reg_wr = '{index: idx, wdata: val};
    feed_ops.push_back(op);
  endtask

  task automatic add_settle();
    feed_op_t op;
    op.kind   = OP_SETTLE;
    op.text   = '0;
    op.reg_wr = '0;
    feed_ops.push_back(op);
  endtask

  task automatic queue_line(bit force_long);
    int         ws_len;
    int         body_len;
    bit         end_alone;
    logic [7:0] b;
    if (!force_long && $urandom_range(0, 11) == 0) begin
      add_text(8'($urandom_range(0, 255)), 1'b0, 1'b1);
      return;
    end
    if (force_long || $urandom_range(0, 59) == 0) ws_len = $urandom_range(120, 135);
    else if ($urandom_range(0, 3) == 0) ws_len = 0;
    else ws_len = $urandom_range(1, 12);
    body_len = ($urandom_range(0, 7) == 0) ? 0 : $urandom_range(1, 6);
    if (ws_len == 0 && body_len == 0) ws_len = 1;
    end_alone = ($urandom_range(0, 3) == 0);
    for (int k = 0; k < ws_len; k++) begin
      if (force_long) b = lis_pkg::CH_TAB;
      else b = $urandom_range(0, 1) ? lis_pkg::CH_TAB : lis_pkg::CH_SPACE;
      add_text(b, 1'b1, (k == ws_len - 1) && (body_len == 0) && !end_alone);
    end
    for (int k = 0; k < body_len; k++) begin
      b = 8'($urandom_range(0, 255));
      if (k == 0) begin
        while (b == lis_pkg::CH_TAB || b == lis_pkg::CH_SPACE) b = 8'($urandom_range(0, 255));
      end else if ($urandom_range(0, 3) == 0) begin
        b = $urandom_range(0, 1) ? lis_pkg::CH_TAB : lis_pkg::CH_SPACE;
      end
      add_text(b, 1'b1, (k == body_len - 1) && !end_alone);
    end
    if (end_alone) add_text(8'($urandom_range(0, 255)), 1'b0, 1'b1);
  endtask

  // Expected result of one text beat, pushed onto awaited when the beat gives one.
  task automatic reindent_beat(input lis_pkg::lis_in_t beat);
    lis_pkg::lis_out_t r;
    int unsigned       tw;
    int unsigned       newcol;
    bit                is_ws;
    bit                eaten;
    bit                close_now;
    bit                empty_line;
    r          = '0;
    close_now  = 1'b0;
    empty_line = 1'b0;
    if (!beat.byte_present && !beat.line_end) return;
    tw = (tab_width_r == 0) ? 1 : (tab_width_r > 32) ? 32 : tab_width_r;
    is_ws = beat.byte_present &&
            (beat.text_byte == lis_pkg::CH_SPACE || beat.text_byte == lis_pkg::CH_TAB);
    eaten = in_indent && is_ws;
    if (in_indent) begin
      if (is_ws) begin
        if (tab_phase >= tw) tab_phase = 0;
        if (beat.text_byte == lis_pkg::CH_SPACE) begin
          column    += 1;
          tab_phase = (tab_phase + 1 == tw) ? 0 : tab_phase + 1;
        end else begin
          column    += tw - tab_phase;
          tab_phase = 0;
        end
        if (column > MAX_COL) column = MAX_COL;
        if (!beat.line_end) return;
        close_now = 1'b1;
      end else begin
        close_now  = 1'b1;
        empty_line = !beat.byte_present && (column == 0);
      end
    end
    if (close_now) begin
      if (empty_line && !keep_empty_r) begin
        newcol = 0;
        r.line_changed = 1'b0;
      end else begin
        if (shift_left_r) newcol = (column > shift_r) ? column - shift_r : 0;
        else newcol = (column + shift_r > MAX_COL) ? MAX_COL : column + shift_r;
        r.line_changed = (newcol != column);
      end
      r.indent_valid = 1'b1;
      r.tab_count    = lis_pkg::TAB_CNT_W'(newcol / tw);
      r.space_count  = lis_pkg::SPACE_W'(newcol % tw);
      in_indent      = 1'b0;
    end
    if (beat.byte_present && !eaten) begin
      r.out_byte         = beat.text_byte;
      r.out_byte_present = 1'b1;
    end
    if (beat.line_end) begin
      r.out_line_end = 1'b1;
      in_indent      = 1'b1;
      column         = 0;
      tab_phase      = 0;
    end
    awaited.push_back(r);
  endtask

  task automatic apply_reg(input lis_pkg::lis_cfg_t w);
    case (w.index)
      lis_pkg::REG_TAB_WIDTH:  tab_width_r  = w.wdata[5:0];
      lis_pkg::REG_SHIFT_AMT:  shift_r      = w.wdata;
      lis_pkg::REG_SHIFT_LEFT: shift_left_r = w.wdata[0];
      lis_pkg::REG_KEEP_EMPTY: keep_empty_r = w.wdata[0];
      default: ;
    endcase
  endtask

  task automatic check_field(string fname, int unsigned want, int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", fname, want, got);
      mismatches++;
    end
  endtask

  // driver
  always @(posedge clk) begin
    if (rst) begin
      feed_ch.valid <= 1'b0;
      feed_ch.data  <= '0;
      cfg_ch.valid  <= 1'b0;
      cfg_ch.data   <= '0;
      feed_gap      = 0;
      settle_cnt    = 0;
    end else begin
      feed_v_next = feed_ch.valid;
      cfg_v_next  = cfg_ch.valid;
      if (feed_ch.valid && feed_ch.ready) begin
        reindent_beat(feed_ch.data);
        feed_v_next = 1'b0;
      end
      if (cfg_ch.valid && cfg_ch.ready) begin
        apply_reg(cfg_ch.data);
        cfg_v_next = 1'b0;
      end
      if (!feed_v_next && !cfg_v_next) begin
        if (feed_gap > 0) begin
          feed_gap--;
        end else if (feed_ops.size() > 0) begin
          case (feed_ops[0].kind)
            OP_TEXT: begin
              feed_ch.data <= feed_ops[0].text;
              feed_v_next = 1'b1;
              void'(feed_ops.pop_front());
              if ($urandom_range(0, 49) == 0) feed_idle_mode = $urandom_range(0, 2);
              feed_gap = draw_wait(feed_idle_mode);
            end
            OP_REG: begin
              cfg_ch.data <= feed_ops[0].reg_wr;
              cfg_v_next = 1'b1;
              void'(feed_ops.pop_front());
            end
            OP_SETTLE: begin
              if (awaited.size() != 0) begin
                settle_cnt = 0;
              end else if (settle_cnt >= SETTLE_CYC) begin
                settle_cnt = 0;
                void'(feed_ops.pop_front());
              end else begin
                settle_cnt++;
              end
            end
            default: ;
          endcase
        end
      end
      feed_ch.valid <= feed_v_next;
      cfg_ch.valid  <= cfg_v_next;
    end
  end

  // monitor
  always @(posedge clk) begin
    lis_pkg::lis_out_t want;
    if (rst) begin
      res_ch.ready <= 1'b0;
      res_hold     = 0;
    end else begin
      if (res_ch.valid && res_ch.ready) begin
        if (awaited.size() == 0) begin
          $error("result beat with no expectation pending");
          mismatches++;
        end else begin
          want = awaited.pop_front();
          check_field("out_byte", want.out_byte, res_ch.data.out_byte);
          check_field("out_byte_present", want.out_byte_present, res_ch.data.out_byte_present);
          check_field("indent_valid", want.indent_valid, res_ch.data.indent_valid);
          check_field("tab_count", want.tab_count, res_ch.data.tab_count);
          check_field("space_count", want.space_count, res_ch.data.space_count);
          check_field("line_changed", want.line_changed, res_ch.data.line_changed);
          check_field("out_line_end", want.out_line_end, res_ch.data.out_line_end);
        end
        if ($urandom_range(0, 49) == 0) res_idle_mode = $urandom_range(0, 2);
        res_hold = draw_wait(res_idle_mode);
      end else if (res_hold > 0) begin
        res_hold--;
      end
      res_ch.ready <= (res_hold == 0);
    end
  end

  always @(posedge clk) begin
    cycles_run++;
    if (cycles_run > LIMIT_CYCLES) begin
      $display("FAIL");
      $finish;
    end
  end

  initial begin
    int unsigned phase_end;
    int          pick;
    bit          first;
    rst            = 1'b1;
    feed_ch.valid  = 1'b0;
    feed_ch.data   = '0;
    cfg_ch.valid   = 1'b0;
    cfg_ch.data    = '0;
    res_ch.ready   = 1'b0;
    text_items     = 0;
    mismatches     = 0;
    cycles_run     = 0;
    feed_idle_mode = 1;
    res_idle_mode  = 1;

    // directed: reset settings, tab 8, shift right 8
    add_text(lis_pkg::CH_SPACE, 1'b1, 1'b0);
    add_text(lis_pkg::CH_SPACE, 1'b1, 1'b0);
    add_text(8'h78, 1'b1, 1'b0);
    add_text(8'hff, 1'b1, 1'b1);
    add_text(8'h55, 1'b0, 1'b1);
    add_text(lis_pkg::CH_TAB, 1'b1, 1'b0);
    add_text(lis_pkg::CH_SPACE, 1'b1, 1'b1);
    add_text(8'h00, 1'b1, 1'b1);
    add_text(8'haa, 1'b0, 1'b0);
    add_text(lis_pkg::CH_TAB, 1'b1, 1'b0);
    add_text(8'h61, 1'b1, 1'b0);
    add_text(8'h00, 1'b0, 1'b1);
    // zero tab width, shift left past zero, empty lines kept
    add_settle();
    add_reg(lis_pkg::REG_TAB_WIDTH, 8'd0);
    add_reg(lis_pkg::REG_SHIFT_AMT, 8'd255);
    add_reg(lis_pkg::REG_SHIFT_LEFT, 8'd1);
    add_reg(lis_pkg::REG_KEEP_EMPTY, 8'd1);
    add_text(8'h00, 1'b0, 1'b1);
    add_text(lis_pkg::CH_SPACE, 1'b1, 1'b0);
    add_text(8'h62, 1'b1, 1'b1);
    // oversized tab width, widest right shift
    add_settle();
    add_reg(lis_pkg::REG_TAB_WIDTH, 8'd63);
    add_reg(lis_pkg::REG_SHIFT_LEFT, 8'd0);
    add_text(8'hff, 1'b0, 1'b1);
    add_text(lis_pkg::CH_TAB, 1'b1, 1'b0);
    add_text(lis_pkg::CH_TAB, 1'b1, 1'b0);
    add_text(lis_pkg::CH_TAB, 1'b1, 1'b0);
    add_text(8'h7f, 1'b1, 1'b1);
    // tab width 1, no shift: unchanged column
    add_settle();
    add_reg(lis_pkg::REG_TAB_WIDTH, 8'd1);
    add_reg(lis_pkg::REG_SHIFT_AMT, 8'd0);
    add_text(lis_pkg::CH_SPACE, 1'b1, 1'b0);
    add_text(8'h80, 1'b1, 1'b1);

    first = 1'b1;
    while (text_items < TEXT_TARGET) begin
      add_settle();
      pick = $urandom_range(0, 5);
      if (first) add_reg(lis_pkg::REG_TAB_WIDTH, 8'd32);
      else if (pick == 0) add_reg(lis_pkg::REG_TAB_WIDTH, 8'd1);
      else if (pick == 1) add_reg(lis_pkg::REG_TAB_WIDTH, 8'd32);
      else if (pick == 2) add_reg(lis_pkg::REG_TAB_WIDTH, 8'($urandom_range(33, 63)));
      else add_reg(lis_pkg::REG_TAB_WIDTH, 8'($urandom_range(0, 32)));
      pick = $urandom_range(0, 3);
      if (pick == 0) add_reg(lis_pkg::REG_SHIFT_AMT, 8'd0);
      else if (pick == 1) add_reg(lis_pkg::REG_SHIFT_AMT, 8'd255);
      else add_reg(lis_pkg::REG_SHIFT_AMT, 8'($urandom_range(0, 255)));
      add_reg(lis_pkg::REG_SHIFT_LEFT, first ? 8'd0 : 8'($urandom_range(0, 1)));
      add_reg(lis_pkg::REG_KEEP_EMPTY, 8'($urandom_range(0, 1)));
      if (first) queue_line(1'b1);
      phase_end = text_items + $urandom_range(60, 140);
      if (phase_end > TEXT_TARGET) phase_end = TEXT_TARGET;
      while (text_items < phase_end) begin
        queue_line(1'b0);
        if ($urandom_range(0, 39) == 0) add_settle();
      end
      first = 1'b0;
    end

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    do @(posedge clk);
    while (feed_ops.size() != 0 || feed_ch.valid || cfg_ch.valid || awaited.size() != 0);
    repeat (SETTLE_CYC) @(posedge clk);

    if (mismatches == 0 && awaited.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
